// ===== rtl/core/fpau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_pkg
// Shared types, constants and elaboration-time helpers for the fixed-point
// activation unit.
// ----------------------------------------------------------------------------
package fpau_pkg;

    // function select codes
    typedef enum logic [1:0] {
        MODE_SIGMOID = 2'd0,
        MODE_TANH    = 2'd1,
        MODE_RELU    = 2'd2,
        MODE_LEAKY   = 2'd3
    } act_mode_t;

    // configuration map
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_IDX_ACT_MODE = '0;

    // internal exponent format: unsigned q2.62
    localparam int QW     = 64;
    localparam int QH     = 32;
    localparam int Q_FRAC = 62;
    localparam logic [QW-1:0] Q_ONE = QW'(1) << Q_FRAC;
    localparam int TAYLOR_TERMS = 24;

    // q2.62 product rounded to nearest
    function automatic logic [QW-1:0] q_mul_round(input logic [QW-1:0] a,
                                                  input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        p = {{QW{1'b0}}, a} * {{QW{1'b0}}, b};
        p = p + ((2*QW)'(1) << (Q_FRAC - 1));
        return p[Q_FRAC +: QW];
    endfunction

    // e^-(2^k / 2^frac_bits) in q2.62, worked out at elaboration
    function automatic logic [QW-1:0] exp_base(input int frac_bits, input int k);
        logic [QW-1:0] term;
        logic [QW-1:0] base;
        term = Q_ONE;
        base = Q_ONE;
        for (int j = 1; j <= TAYLOR_TERMS; j++) begin
            term = (term >> frac_bits) / QW'(j);
            if (j % 2 == 1) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        for (int j = 0; j < k; j++) begin
            base = q_mul_round(base, base);
        end
        return base;
    endfunction

endpackage

// ===== rtl/core/fixed_point_activation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_activation_unit
// Element-wise sigmoid / tanh / relu / leaky relu on signed fixed-point values,
// fully pipelined, one item per clock while the skid stage is empty.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------
//  s_        in         s_tvalid / s_tready       s_tdata: z_value
//  m_        out        m_tvalid / m_tready       m_tdata: a_value
//  apb       in         psel / penable / pready   act_mode at byte address 0
//
//  one item enters per clock while the skid stage is empty; the path runs
//  through the exponent chain of two stages per magnitude bit and the
//  restoring divider of one quotient bit per stage
//  aresetn is synchronous and clears all valid bits, the skid stage and
//  act_mode; no clearing pass is needed
//  a held result parks in the output register, the next one in a skid stage;
//  s_tready is the inverse of the registered skid flag, so the pipe freezes
//  as a whole and nothing is dropped or repeated
//
module fixed_point_activation_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 11
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,   // [DATA_WIDTH-1:0] z_value
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_tdata,   // [DATA_WIDTH-1:0] a_value
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpau_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fpau_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fpau_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int E_BITS     = DATA_WIDTH + 1;          // exponent magnitude, tanh doubles it
    localparam int Q_BITS     = FRAC_BITS + 2;           // quotient bits of the divider
    localparam int RES_W      = (DATA_WIDTH > Q_BITS) ? DATA_WIDTH : Q_BITS;
    localparam int unsigned LEAKY_COEF = ((1 << FRAC_BITS) + 50) / 100;
    localparam int COEF_W     = $clog2(LEAKY_COEF + 2);
    localparam int PROD_W     = DATA_WIDTH + COEF_W;
    localparam int SUM_W      = PROD_W + FRAC_BITS + 1;
    localparam logic [COEF_W-1:0] COEF     = COEF_W'(LEAKY_COEF);
    localparam logic [SUM_W-1:0]  HALF_LSB = SUM_W'(1) << (FRAC_BITS - 1);
    localparam int QW = fpau_pkg::QW;
    localparam int QH = fpau_pkg::QH;

    typedef struct packed {
        fpau_pkg::act_mode_t     mode;
        logic                    neg;
        logic [E_BITS-1:0]       emag;
        logic [DATA_WIDTH-1:0]   simple;   // relu / leaky relu result
    } exp_side_t;

    typedef struct packed {
        fpau_pkg::act_mode_t     mode;
        logic                    neg;
        logic [DATA_WIDTH-1:0]   simple;
    } div_side_t;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    fpau_pkg::act_mode_t act_mode_reg;
    logic                cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[fpau_pkg::CFG_ADDR_W-1:2] == fpau_pkg::REG_IDX_ACT_MODE);
    assign prdata  = cfg_hit ? fpau_pkg::CFG_DATA_W'(act_mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_mode_reg <= fpau_pkg::MODE_SIGMOID;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            act_mode_reg <= fpau_pkg::act_mode_t'(pwdata[1:0]);
        end
    end

    // ------------------------------------------------------------------
    // flow control: the whole pipe moves while the skid stage is empty
    // ------------------------------------------------------------------
    logic en;
    logic skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // s1: input register
    // ------------------------------------------------------------------
    logic                    s1_vld_reg;
    logic [DATA_WIDTH-1:0]   s1_raw_reg;
    fpau_pkg::act_mode_t     s1_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_raw_reg  <= s_tdata[DATA_WIDTH-1:0];
            s1_mode_reg <= act_mode_reg;
        end
    end

    // ------------------------------------------------------------------
    // s2: sign and magnitude
    // ------------------------------------------------------------------
    logic                    s2_vld_reg;
    logic                    s2_neg_reg;
    logic [DATA_WIDTH-1:0]   s2_mag_reg;
    logic [E_BITS-1:0]       s2_emag_reg;
    fpau_pkg::act_mode_t     s2_mode_reg;
    logic                    s1_neg;
    logic [DATA_WIDTH-1:0]   s1_mag;

    assign s1_neg = s1_raw_reg[DATA_WIDTH-1];
    assign s1_mag = s1_neg ? (~s1_raw_reg + 1'b1) : s1_raw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_neg_reg  <= s1_neg;
            s2_mag_reg  <= s1_mag;
            s2_mode_reg <= s1_mode_reg;
            // tanh works on e^-2|x|
            s2_emag_reg <= (s1_mode_reg == fpau_pkg::MODE_TANH) ? {s1_mag, 1'b0}
                                                                 : {1'b0, s1_mag};
        end
    end

    // ------------------------------------------------------------------
    // s3: leaky slope product
    // ------------------------------------------------------------------
    logic                    s3_vld_reg;
    logic                    s3_neg_reg;
    logic [DATA_WIDTH-1:0]   s3_mag_reg;
    logic [E_BITS-1:0]       s3_emag_reg;
    fpau_pkg::act_mode_t     s3_mode_reg;
    logic [PROD_W-1:0]       s3_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_neg_reg  <= s2_neg_reg;
            s3_mag_reg  <= s2_mag_reg;
            s3_emag_reg <= s2_emag_reg;
            s3_mode_reg <= s2_mode_reg;
            s3_prod_reg <= PROD_W'(s2_mag_reg) * PROD_W'(COEF);
        end
    end

    // ------------------------------------------------------------------
    // s4: relu / leaky relu result, rounded half up on the magnitude
    // ------------------------------------------------------------------
    logic                    s4_vld_reg;
    exp_side_t               s4_side_reg;
    logic [SUM_W-1:0]        s3_leak_sum;
    logic [DATA_WIDTH-1:0]   s3_leak_mag;
    logic [DATA_WIDTH-1:0]   s3_simple;

    assign s3_leak_sum = SUM_W'(s3_prod_reg) + HALF_LSB;
    assign s3_leak_mag = s3_leak_sum[FRAC_BITS +: DATA_WIDTH];

    always_comb begin
        case (s3_mode_reg)
            fpau_pkg::MODE_RELU:  s3_simple = s3_neg_reg ? '0 : s3_mag_reg;
            fpau_pkg::MODE_LEAKY: s3_simple = s3_neg_reg ? (~s3_leak_mag + 1'b1)
                                                         : s3_mag_reg;
            default:              s3_simple = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_side_reg.mode   <= s3_mode_reg;
            s4_side_reg.neg    <= s3_neg_reg;
            s4_side_reg.emag   <= s3_emag_reg;
            s4_side_reg.simple <= s3_simple;
        end
    end

    // ------------------------------------------------------------------
    // exponent chain: e^-t as a product of e^-(2^k lsb) for each set bit,
    // one rounded q2.62 multiply per bit in two stages
    // (partial products, then sum and round)
    // ------------------------------------------------------------------
    logic [QW-1:0]   exp_acc  [0:E_BITS];
    exp_side_t       exp_side [0:E_BITS];
    logic            exp_vld  [0:E_BITS];

    assign exp_acc[0]  = fpau_pkg::Q_ONE;
    assign exp_side[0] = s4_side_reg;
    assign exp_vld[0]  = s4_vld_reg;

    for (genvar k = 0; k < E_BITS; k++) begin : g_exp
        localparam logic [QW-1:0] BASE = fpau_pkg::exp_base(FRAC_BITS, k);

        logic [2*QH-1:0] pp_ll_reg;
        logic [2*QH-1:0] pp_lh_reg;
        logic [2*QH-1:0] pp_hl_reg;
        logic [2*QH-1:0] pp_hh_reg;
        logic [QW-1:0]   keep_reg;
        exp_side_t       side_m_reg;
        logic            vld_m_reg;
        logic [QW-1:0]   acc_reg;
        exp_side_t       side_c_reg;
        logic            vld_c_reg;
        logic [2*QW-1:0] sum;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_m_reg <= 1'b0;
                vld_c_reg <= 1'b0;
            end else if (en) begin
                vld_m_reg <= exp_vld[k];
                vld_c_reg <= vld_m_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pp_ll_reg  <= exp_acc[k][QH-1:0]  * BASE[QH-1:0];
                pp_lh_reg  <= exp_acc[k][QH-1:0]  * BASE[QW-1:QH];
                pp_hl_reg  <= exp_acc[k][QW-1:QH] * BASE[QH-1:0];
                pp_hh_reg  <= exp_acc[k][QW-1:QH] * BASE[QW-1:QH];
                keep_reg   <= exp_acc[k];
                side_m_reg <= exp_side[k];
            end
        end

        assign sum = (2*QW)'(pp_ll_reg)
                   + ((2*QW)'(pp_lh_reg) << QH)
                   + ((2*QW)'(pp_hl_reg) << QH)
                   + ((2*QW)'(pp_hh_reg) << QW)
                   + ((2*QW)'(1) << (fpau_pkg::Q_FRAC - 1));

        always_ff @(posedge aclk) begin
            if (en) begin
                // multiply in only where this magnitude bit is set
                acc_reg    <= side_m_reg.emag[k] ? sum[fpau_pkg::Q_FRAC +: QW] : keep_reg;
                side_c_reg <= side_m_reg;
            end
        end

        assign exp_acc[k+1]  = acc_reg;
        assign exp_side[k+1] = side_c_reg;
        assign exp_vld[k+1]  = vld_c_reg;
    end

    // ------------------------------------------------------------------
    // divider setup: sigmoid e/(1+e) or 1/(1+e), tanh (1-e)/(1+e)
    // ------------------------------------------------------------------
    logic            d0_vld_reg;
    logic [QW-1:0]   d0_num_reg;
    logic [QW-1:0]   d0_den_reg;
    div_side_t       d0_side_reg;
    logic [QW-1:0]   e_last;
    exp_side_t       e_side;

    assign e_last = exp_acc[E_BITS];
    assign e_side = exp_side[E_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_vld_reg <= 1'b0;
        end else if (en) begin
            d0_vld_reg <= exp_vld[E_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (e_side.mode == fpau_pkg::MODE_TANH) begin
                d0_num_reg <= fpau_pkg::Q_ONE - e_last;
            end else begin
                d0_num_reg <= e_side.neg ? e_last : fpau_pkg::Q_ONE;
            end
            d0_den_reg         <= fpau_pkg::Q_ONE + e_last;
            d0_side_reg.mode   <= e_side.mode;
            d0_side_reg.neg    <= e_side.neg;
            d0_side_reg.simple <= e_side.simple;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage; the first stage takes
    // the integer bit without a shift
    // ------------------------------------------------------------------
    logic [QW-1:0]     div_rem  [0:Q_BITS];
    logic [QW-1:0]     div_den  [0:Q_BITS];
    logic [Q_BITS-1:0] div_q    [0:Q_BITS];
    div_side_t         div_side [0:Q_BITS];
    logic              div_vld  [0:Q_BITS];

    assign div_rem[0]  = d0_num_reg;
    assign div_den[0]  = d0_den_reg;
    assign div_q[0]    = '0;
    assign div_side[0] = d0_side_reg;
    assign div_vld[0]  = d0_vld_reg;

    for (genvar i = 0; i < Q_BITS; i++) begin : g_div
        logic [QW-1:0]     rem_reg;
        logic [QW-1:0]     den_reg;
        logic [Q_BITS-1:0] q_reg;
        div_side_t         side_reg;
        logic              vld_reg;
        logic [QW:0]       rem_s;
        logic [QW:0]       rem_d;
        logic              ge;

        if (i == 0) begin : g_first
            assign rem_s = {1'b0, div_rem[i]};
        end else begin : g_shift
            assign rem_s = {div_rem[i], 1'b0};
        end

        assign rem_d = rem_s - {1'b0, div_den[i]};
        assign ge    = (rem_s >= {1'b0, div_den[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= div_vld[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg  <= ge ? rem_d[QW-1:0] : rem_s[QW-1:0];
                den_reg  <= div_den[i];
                q_reg    <= {div_q[i][Q_BITS-2:0], ge};
                side_reg <= div_side[i];
            end
        end

        assign div_rem[i+1]  = rem_reg;
        assign div_den[i+1]  = den_reg;
        assign div_q[i+1]    = q_reg;
        assign div_side[i+1] = side_reg;
        assign div_vld[i+1]  = vld_reg;
    end

    // ------------------------------------------------------------------
    // final rounding and result select
    // ------------------------------------------------------------------
    logic [Q_BITS:0]         q_plus;
    logic [RES_W-1:0]        curve_mag;
    logic [RES_W-1:0]        curve_res;
    logic [DATA_WIDTH-1:0]   pipe_data;
    logic                    pipe_vld;
    div_side_t               last_side;

    assign last_side = div_side[Q_BITS];
    assign pipe_vld  = div_vld[Q_BITS];
    assign q_plus    = {1'b0, div_q[Q_BITS]} + 1'b1;
    assign curve_mag = RES_W'(q_plus[Q_BITS:1]);
    // tanh is odd: round the magnitude, then negate
    assign curve_res = (last_side.mode == fpau_pkg::MODE_TANH && last_side.neg)
                     ? (~curve_mag + 1'b1) : curve_mag;

    always_comb begin
        case (last_side.mode)
            fpau_pkg::MODE_RELU,
            fpau_pkg::MODE_LEAKY: pipe_data = last_side.simple;
            default:              pipe_data = curve_res[DATA_WIDTH-1:0];
        endcase
    end

    // ------------------------------------------------------------------
    // output register and skid stage
    // ------------------------------------------------------------------
    logic                    out_vld_reg;
    logic [DATA_WIDTH-1:0]   out_data_reg;
    logic [DATA_WIDTH-1:0]   skid_data_reg;
    logic                    out_free;

    assign out_free = m_tready || !out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= pipe_vld;
            end
        end else if (en && pipe_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : pipe_data;
        end
        if (!out_free && en) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);

endmodule

// ===== rtl/core/fpau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_checker
// Port-level assertions for the activation unit, bound to its top level.
// ----------------------------------------------------------------------------
module fpau_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0]  m_tdata
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // input stalls only while a result is parked at the output
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no result waiting");

    // a taken result always frees the skid stage
    a_ready_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |=> s_tready)
        else $error("s_tready low after m_tready");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind fixed_point_activation_unit fpau_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_fpau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
